// ===== hw/rtl/ett_pkg.sv =====
package ett_pkg;

	// Default table size and the most events one tick may fire.
	localparam int NumTimersDefault = 16;
	localparam int MaxResults       = 16;

	// Depth of the command queue between front and back, a power of two.
	localparam int QueueDepth = 2;

	// Input function codes.
	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Result kind codes.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_EVENT  = 1'b1;

	// Add status codes.
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] duration;
		logic [7:0]  event_code;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic       status;
		logic [7:0] fired_event;
		logic       last;
	} rsp_t;

	typedef enum logic {
		OP_ADD,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] duration;
		logic [7:0]  event_code;
	} cmd_t;

endpackage

// ===== hw/rtl/ett_front.sv =====
module ett_front
	import ett_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic cmd_valid,
	input  logic cmd_ready,
	output cmd_t cmd
);

	localparam int PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int FillW = $clog2(QueueDepth + 1);

	cmd_t             queue_q [QueueDepth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [FillW-1:0] fill_q;
	cmd_t             cmd_in;
	logic             push;
	logic             pop;

	// Decode the function bit into a back-end operation.
	always_comb begin
		cmd_in.op         = (req.func == FUNC_TICK) ? OP_TICK : OP_ADD;
		cmd_in.duration   = req.duration;
		cmd_in.event_code = req.event_code;
	end

	assign req_ready = (fill_q != FillW'(QueueDepth));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FillW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FillW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

// ===== hw/rtl/ett_engine.sv =====
module ett_engine
	import ett_pkg::*;
#(
	parameter int NUM_TIMERS = NumTimersDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int FW = $clog2(MaxResults + 1);

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] duration;
		logic [7:0]  event_code;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_COMPACT
	} state_t;

	entry_t mem [NUM_TIMERS];
	entry_t rdata_q;

	state_t         state_q, state_d;
	logic [31:0]    now_q, now_d;
	logic [CW-1:0]  count_q, count_d;
	logic [IW-1:0]  idx_q, idx_d;
	logic [FW-1:0]  found_q, found_d;
	logic           pend_q, pend_d;
	logic [7:0]     pend_ev_q, pend_ev_d;
	logic [IW-1:0]  stop_idx_q, stop_idx_d;
	logic [CW-1:0]  w_q, w_d;
	rsp_t           out_q, out_d;
	logic           out_valid_q;
	logic           out_load;
	logic           out_free;

	logic           wr_en;
	logic [IW-1:0]  wr_addr;
	entry_t         wr_data;
	logic [IW-1:0]  rd_addr;

	logic [CW-1:0]  cnt_m1_full;
	logic [IW-1:0]  cnt_m1;
	logic [31:0]    elapsed;
	logic           expired;
	logic           gone;
	logic           done;

	assign out_free    = !out_valid_q || rsp_ready;
	assign rsp_valid   = out_valid_q;
	assign rsp         = out_q;
	assign cnt_m1_full = count_q - CW'(1);
	assign cnt_m1      = cnt_m1_full[IW-1:0];
	assign elapsed     = now_q - rdata_q.start;
	assign expired     = elapsed > rdata_q.duration;
	assign gone        = expired && (idx_q >= stop_idx_q);

	always_comb begin
		state_d    = state_q;
		now_d      = now_q;
		count_d    = count_q;
		idx_d      = idx_q;
		found_d    = found_q;
		pend_d     = pend_q;
		pend_ev_d  = pend_ev_q;
		stop_idx_d = stop_idx_q;
		w_d        = w_q;
		out_load   = 1'b0;
		out_d      = '0;
		cmd_ready  = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = '0;
		rd_addr    = '0;
		done       = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == OP_ADD) begin
						if (out_free) begin
							cmd_ready  = 1'b1;
							out_load   = 1'b1;
							out_d.kind = KIND_STATUS;
							out_d.last = 1'b1;
							if (count_q == CW'(NUM_TIMERS)) begin
								out_d.status = STATUS_FULL;
							end else begin
								out_d.status       = STATUS_OK;
								wr_en              = 1'b1;
								wr_addr            = count_q[IW-1:0];
								wr_data.start      = now_q;
								wr_data.duration   = cmd.duration;
								wr_data.event_code = cmd.event_code;
								count_d            = count_q + CW'(1);
							end
						end
					end else begin
						cmd_ready = 1'b1;
						now_d     = now_q + 32'd1;
						found_d   = '0;
						pend_d    = 1'b0;
						if (count_q != '0) begin
							idx_d   = cnt_m1;
							rd_addr = cnt_m1;
							state_d = ST_SCAN;
						end
					end
				end
			end

			ST_SCAN: begin
				if (expired && pend_q && !out_free) begin
					// Hold the read so the same entry is presented again.
					rd_addr = idx_q;
				end else begin
					if (expired) begin
						if (pend_q) begin
							out_load          = 1'b1;
							out_d.kind        = KIND_EVENT;
							out_d.status      = STATUS_OK;
							out_d.fired_event = pend_ev_q;
							out_d.last        = 1'b0;
						end
						pend_d    = 1'b1;
						pend_ev_d = rdata_q.event_code;
						found_d   = found_q + FW'(1);
					end
					done = (idx_q == '0) ||
						(expired && (found_q + FW'(1) == FW'(MaxResults)));
					if (done) begin
						stop_idx_d = idx_q;
						state_d    = (pend_q || expired) ? ST_FLUSH : ST_IDLE;
					end else begin
						idx_d   = idx_q - IW'(1);
						rd_addr = idx_q - IW'(1);
					end
				end
			end

			ST_FLUSH: begin
				rd_addr = '0;
				if (out_free) begin
					out_load          = 1'b1;
					out_d.kind        = KIND_EVENT;
					out_d.status      = STATUS_OK;
					out_d.fired_event = pend_ev_q;
					out_d.last        = 1'b1;
					pend_d            = 1'b0;
					idx_d             = '0;
					w_d               = '0;
					state_d           = ST_COMPACT;
				end
			end

			ST_COMPACT: begin
				if (!gone) begin
					wr_en   = 1'b1;
					wr_addr = w_q[IW-1:0];
					wr_data = rdata_q;
					w_d     = w_q + CW'(1);
				end
				rd_addr = idx_q + IW'(1);
				if (idx_q == cnt_m1) begin
					count_d = gone ? w_q : (w_q + CW'(1));
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			found_q     <= '0;
			pend_q      <= 1'b0;
			pend_ev_q   <= '0;
			stop_idx_q  <= '0;
			w_q         <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			state_q    <= state_d;
			now_q      <= now_d;
			count_q    <= count_d;
			idx_q      <= idx_d;
			found_q    <= found_d;
			pend_q     <= pend_d;
			pend_ev_q  <= pend_ev_d;
			stop_idx_q <= stop_idx_d;
			w_q        <= w_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q       <= out_d;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Timer table: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

endmodule

// ===== hw/rtl/expiring_timer_table.sv =====
// Expiring timer table: a store of up to NUM_TIMERS one-shot millisecond timers.
// The request channel (req_valid, req_ready, req) carries add and tick beats.
// An add beat stores a duration and an event code stamped with the current
// millisecond count and is answered by one status beat on the response channel
// (rsp_valid, rsp_ready, rsp), with status full when every slot is taken.
// A tick beat advances the counter by one and scans the timers newest first;
// each timer whose elapsed time exceeds its duration fires one event beat and is
// removed. At most sixteen events fire per tick, and the final one carries last.
// Requests enter a two-deep command queue, so a few beats are taken while the
// engine is busy. An add passes through the queue and the response register,
// and the engine takes one add per cycle while the response side keeps up. A
// tick scans the table memory one entry per cycle unless a result stalls; when
// any timer fired, a flush state and a compaction pass close the gaps. A stall
// on the response side holds the engine at its next result, while the queue
// keeps taking requests until it is full.
// Reset clears the counter, the timer count and the queue; no clearing pass
// of the table memory is needed.
module expiring_timer_table
	import ett_pkg::*;
#(
	parameter int NUM_TIMERS = NumTimersDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	// Front end: decodes each request beat and queues it as a command.
	ett_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Back end: owns the timer table, the millisecond counter and the
	// response register.
	ett_engine #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== hw/rtl/ett_checker.sv =====
module ett_checker
	import ett_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp))
		else $error("response payload changed while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == KIND_STATUS) |-> rsp.last)
		else $error("add status beat without last mark");

	a_event_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == KIND_EVENT) |-> (rsp.status == STATUS_OK))
		else $error("event beat with full status");

endmodule

bind expiring_timer_table ett_checker u_ett_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ===== test/testbench.sv =====
module testbench;
	import ett_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The run is bounded by a cycle count. The slowest correct run is about
	// 330 beats, each with the longest send gap, a tick with compaction, and
	// sixteen events each held up as long as the receiver allows; the limit is
	// several times that.
	localparam int CycleLimit  = 400000;
	// Once nothing more is expected, give the engine time to finish a full
	// scan and compaction pass, plus the queue ahead of it.
	localparam int SettleCycles = 80;
	localparam int RandomBlocks = 31;
	localparam int BlockBeats   = 10;

	// Results that can be read straight off the behavior of an add.
	localparam rsp_t ADD_OK   = '{kind: KIND_STATUS, status: STATUS_OK,
		fired_event: 8'h00, last: 1'b1};
	localparam rsp_t ADD_FULL = '{kind: KIND_STATUS, status: STATUS_FULL,
		fired_event: 8'h00, last: 1'b1};

	// One stimulus beat. A negative known_count means the results come from
	// the timer predictor; 0 or 1 means the results are typed in here.
	typedef struct {
		req_t beat;
		int   known_count;
		rsp_t known_rsp;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	expiring_timer_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Shadow copy of the timer table, kept oldest first like the block.
	logic [31:0] shadow_ms;
	int          shadow_count;
	logic [31:0] shadow_start [NumTimersDefault];
	logic [31:0] shadow_dur   [NumTimersDefault];
	logic [7:0]  shadow_code  [NumTimersDefault];

	rsp_t      pending_results[$];  // results the block still owes, oldest first
	rsp_t      beat_results[$];     // results caused by the latest request beat
	stim_row_t directed_rows[$];
	stim_row_t in_flight;           // the row currently offered on the request side

	int  req_beats;
	int  rsp_beats;
	int  errors;
	int  cycles;
	int  adds_sent;
	int  adds_refused;
	int  ticks_sent;
	int  events_fired;
	bit  calm;                      // no idling on either side while set

	// Work out what one request beat causes, and update the shadow table.
	function automatic void predict_timers(input req_t r);
		bit   gone [NumTimersDefault];
		int   fired;
		int   w;
		rsp_t one;
		beat_results = {};
		if (r.func == FUNC_ADD) begin
			one = ADD_FULL;
			if (shadow_count < NumTimersDefault) begin
				shadow_start[shadow_count] = shadow_ms;
				shadow_dur[shadow_count]   = r.duration;
				shadow_code[shadow_count]  = r.event_code;
				shadow_count++;
				one = ADD_OK;
			end
			beat_results.push_back(one);
			return;
		end
		// A tick moves the clock first; the whole scan then uses that value.
		shadow_ms = shadow_ms + 32'd1;
		fired = 0;
		for (int i = shadow_count - 1; i >= 0 && fired < MaxResults; i--) begin
			// Elapsed time wraps modulo 2^32 because both sides are 32 bits.
			if (32'(shadow_ms - shadow_start[i]) > shadow_dur[i]) begin
				gone[i] = 1'b1;
				one = '{kind: KIND_EVENT, status: STATUS_OK,
					fired_event: shadow_code[i], last: 1'b0};
				beat_results.push_back(one);
				fired++;
			end
		end
		if (fired > 0)
			beat_results[fired - 1].last = 1'b1;
		// Close the gaps left by fired timers, keeping the survivors in order.
		w = 0;
		for (int i = 0; i < shadow_count; i++) begin
			if (!gone[i]) begin
				shadow_start[w] = shadow_start[i];
				shadow_dur[w]   = shadow_dur[i];
				shadow_code[w]  = shadow_code[i];
				w++;
			end
		end
		shadow_count = w;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic stim_row_t make_row(input logic func, input logic [31:0] duration,
			input logic [7:0] code, input int known_count, input rsp_t known_rsp);
		stim_row_t row;
		row.beat        = '{func: func, duration: duration, event_code: code};
		row.known_count = known_count;
		row.known_rsp   = known_rsp;
		return row;
	endfunction

	// Offer one beat, after a random gap unless the calm flag is set, and hold
	// it until the monitor has seen it accepted. Called at a falling edge.
	task automatic send_beat(input stim_row_t row);
		int gap;
		int seen;
		gap = calm ? 0 : $urandom_range(9);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_flight = row;
		req       = row.beat;
		req_valid = 1'b1;
		seen      = req_beats;
		do @(negedge clk); while (req_beats == seen);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: everything is sampled at the rising edge, while the inputs only
	// change at the falling edge, so nothing here races the driver.
	always @(posedge clk) begin
		rsp_t want;
		if (req_valid === 1'b1 && req_ready === 1'b1) begin
			predict_timers(req);
			if (req.func == FUNC_ADD) begin
				adds_sent++;
				if (beat_results[0].status == STATUS_FULL)
					adds_refused++;
			end else begin
				ticks_sent++;
				events_fired += beat_results.size();
			end
			// Typed-in rows override the prediction; the shadow table still
			// advances so that later rows see the right state.
			if (in_flight.known_count < 0) begin
				foreach (beat_results[k])
					pending_results.push_back(beat_results[k]);
			end else if (in_flight.known_count == 1) begin
				pending_results.push_back(in_flight.known_rsp);
			end
			req_beats++;
		end
		if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			rsp_beats++;
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result beat, expected none, actual %p", $time, rsp);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 8'(want.kind), 8'(rsp.kind));
				check_field("status", 8'(want.status), 8'(rsp.status));
				check_field("fired_event", want.fired_event, rsp.fired_event);
				check_field("last", 8'(want.last), 8'(rsp.last));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycles, pending_results.size());
			$display("testbench failed");
			$finish;
		end
	end

	// Response side: before each result beat, hold ready low for a random
	// number of cycles, then keep it high until that beat goes through.
	initial begin
		int stall;
		int seen;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(9);
			if (stall > 0) begin
				rsp_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready = 1'b1;
			seen      = rsp_beats;
			do @(negedge clk); while (rsp_beats == seen);
		end
	end

	initial begin
		stim_row_t   row;
		int          add_pct;
		int          pick;
		logic [31:0] dur;

		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		in_flight    = make_row(FUNC_TICK, '0, '0, 0, ADD_OK);
		calm         = 1'b0;
		req_beats    = 0;
		rsp_beats    = 0;
		errors       = 0;
		cycles       = 0;
		adds_sent    = 0;
		adds_refused = 0;
		ticks_sent   = 0;
		events_fired = 0;
		shadow_ms    = '0;
		shadow_count = 0;

		// Directed part. A tick on the empty table fires nothing, and its
		// duration and event fields are junk that must be ignored.
		directed_rows.push_back(make_row(FUNC_TICK, 32'hFFFF_FFFF, 8'hFF, 0, ADD_OK));
		// The first adds after reset are always stored. A zero duration expires
		// on the very next tick; the all-ones duration never expires at all.
		directed_rows.push_back(make_row(FUNC_ADD, 32'h0000_0000, 8'hFF, 1, ADD_OK));
		directed_rows.push_back(make_row(FUNC_ADD, 32'hFFFF_FFFF, 8'h00, 1, ADD_OK));
		directed_rows.push_back(make_row(FUNC_ADD, 32'h0000_0001, 8'h55, -1, ADD_OK));
		directed_rows.push_back(make_row(FUNC_TICK, 32'h0000_0000, 8'h00, -1, ADD_OK));
		directed_rows.push_back(make_row(FUNC_TICK, 32'h1234_5678, 8'hA5, -1, ADD_OK));
		directed_rows.push_back(make_row(FUNC_ADD, 32'h8000_0000, 8'h80, -1, ADD_OK));
		// Fill every remaining slot with timers that all expire on the next
		// tick, so that one tick fires a long burst newest first.
		for (int i = 0; i < NumTimersDefault - 2; i++)
			directed_rows.push_back(make_row(FUNC_ADD, 32'h0, 8'(8'h10 + i), -1, ADD_OK));
		// Table full: the add is refused and nothing is stored.
		directed_rows.push_back(make_row(FUNC_ADD, 32'h0, 8'h7E, 1, ADD_FULL));
		directed_rows.push_back(make_row(FUNC_TICK, 32'h0, 8'h00, -1, ADD_OK));
		// Only the two long timers remain, so this tick gives nothing.
		directed_rows.push_back(make_row(FUNC_TICK, 32'h0, 8'h00, 0, ADD_OK));

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[k])
			send_beat(directed_rows[k]);

		// Random part, in blocks that either lean toward adds (filling the
		// table, often up to full) or toward ticks (draining it). Some blocks
		// run with no idling on either side.
		for (int blk = 0; blk < RandomBlocks; blk++) begin
			calm    = ($urandom_range(3) == 0);
			add_pct = $urandom_range(1) ? 75 : 30;
			for (int j = 0; j < BlockBeats; j++) begin
				pick = $urandom_range(99);
				// Most durations are short so timers fire during the run; a
				// few are huge and effectively stay for good, so keep them rare.
				if (pick < 1)
					dur = 32'hFFFF_FFFF;
				else if (pick < 2)
					dur = $urandom;
				else if (pick < 15)
					dur = $urandom_range(60);
				else
					dur = $urandom_range(12);
				if ($urandom_range(99) < add_pct)
					row = make_row(FUNC_ADD, dur, 8'($urandom_range(255)), -1, ADD_OK);
				else
					row = make_row(FUNC_TICK, $urandom, 8'($urandom_range(255)), -1, ADD_OK);
				send_beat(row);
			end
		end
		calm = 1'b0;
		req_valid = 1'b0;

		// Wait for every owed result, then let the engine settle so that a
		// stray late result would still be caught.
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);

		$display("Covered %0d adds (%0d refused on a full table) and %0d ticks.",
			adds_sent, adds_refused, ticks_sent);
		$display("Checked %0d result beats, %0d of them timer events, %0d errors.",
			rsp_beats, events_fired, errors);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
